@@ rtl/gidg_pkg.sv @@
// Shared constants and types of the goal inverse-distance gain block.
// No dependencies; every module of the block imports it.
package gidg_pkg;

   // Field and datapath widths
   localparam int COORD_W    = 24;              // Q15.8 coordinate
   localparam int MAG_W      = 24;              // |voxel - goal|
   localparam int SQ_W       = 2 * MAG_W;       // one squared axis
   localparam int SUM_W      = SQ_W + 2;        // sum of three squares
   localparam int RAD_SHIFT  = 14;              // Q.16 to Q.30 before the root
   localparam int RAD_W      = SUM_W + RAD_SHIFT;
   localparam int ROOT_W     = RAD_W / 2;       // distance, Q.15
   localparam int CAP_W      = 24;              // per-voxel gain cap, Q16.8
   localparam int ADD_W      = 32;              // per-voxel gain, Q.16
   localparam int PROD_W     = ROOT_W + CAP_W;  // distance times cap
   localparam int GAIN_W     = 48;              // gain sum, Q32.16
   localparam int COUNT_W    = 17;
   localparam int STEP_CNT_W = 5;

   localparam int SQ_STEPS   = MAG_W;

   // Kept-voxel limit: MAX_VOXELS, or the largest count the field holds
   localparam int MAX_VOXELS = 65536;
   localparam int COUNT_FIELD_MAX = (2 ** COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      COUNT_W'((MAX_VOXELS < COUNT_FIELD_MAX) ? MAX_VOXELS : COUNT_FIELD_MAX);

   localparam logic [GAIN_W-1:0] GAIN_MAX         = '1;
   localparam logic [CAP_W-1:0]  GAIN_LIMIT_RESET = CAP_W'(25600);
   localparam logic [PROD_W-1:0] NEAR_LIMIT       = PROD_W'(1) << 23;
   localparam logic [ROOT_W-1:0] RECIP_NUM        = ROOT_W'(1) << 31;

   typedef enum logic [1:0] {
      CSR_GOAL_X,
      CSR_GOAL_Y,
      CSR_GOAL_Z,
      CSR_GAIN_LIMIT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_LAUNCH,
      ST_ROOT,
      ST_RECIP,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/gidg_isqrt.sv @@
// Bit-serial integer square root, one root bit per cycle.
// Depends on gidg_pkg.
module gidg_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gidg_pkg::RAD_W-1:0]    radicand,
   output logic                          done,
   output logic [gidg_pkg::ROOT_W-1:0]   root
);
   import gidg_pkg::*;

   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [ROOT_W+1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_W+1:0]     rem_raw;
   logic [ROOT_W+1:0]     trial;

   always_comb begin
      // bring down the next two radicand bits, try root*4+1
      rem_raw = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_raw >= trial) begin
            rem_in  = rem_raw - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_raw;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ rtl/gidg_recip.sv @@
// Per-voxel gain: bit-serial 2^31 / distance and a shift-add distance * cap
// product run side by side; the product picks quotient or cap. Uses gidg_pkg.
module gidg_recip (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gidg_pkg::ROOT_W-1:0]   distance,
   input  logic [gidg_pkg::CAP_W-1:0]    gain_limit,
   output logic                          done,
   output logic [gidg_pkg::ADD_W-1:0]    gain
);
   import gidg_pkg::*;

   logic [ROOT_W-1:0]     dist_ff, dist_in;
   logic [ROOT_W:0]       rem_ff, rem_in;
   logic [ROOT_W-1:0]     num_ff, num_in;
   logic [ROOT_W-1:0]     quo_ff, quo_in;
   logic [PROD_W-1:0]     dsh_ff, dsh_in;
   logic [CAP_W-1:0]      mgb_ff, mgb_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_W:0]       rem_raw;

   always_comb begin
      rem_raw = {rem_ff[ROOT_W-1:0], num_ff[ROOT_W-1]};
      dist_in = dist_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      dsh_in  = dsh_ff;
      mgb_in  = mgb_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dist_in = distance;
         rem_in  = '0;
         num_in  = RECIP_NUM;
         quo_in  = '0;
         dsh_in  = PROD_W'(distance);
         mgb_in  = gain_limit;
         prod_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring division step
         num_in = num_ff << 1;
         if (rem_raw >= {1'b0, dist_ff}) begin
            rem_in = rem_raw - {1'b0, dist_ff};
            quo_in = {quo_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_raw;
            quo_in = {quo_ff[ROOT_W-2:0], 1'b0};
         end
         // shift-add product, one cap bit per cycle
         if (mgb_ff[0]) begin
            prod_in = prod_ff + dsh_ff;
         end
         dsh_in = dsh_ff << 1;
         mgb_in = mgb_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      dsh_ff  <= dsh_in;
      mgb_ff  <= mgb_in;
      prod_ff <= prod_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // far enough away: 1/distance, else the cap
   assign done = done_ff;
   assign gain = (prod_ff > NEAR_LIMIT) ? ADD_W'(quo_ff) : {gain_limit, 8'b0};

endmodule

@@ rtl/goal_inverse_distance_gain.sv @@
// Top level of the goal inverse-distance gain block; instantiates gidg_isqrt
// and gidg_recip, and uses gidg_pkg for widths, codes and state names.
//
// Sums, over the unobserved voxels of one trajectory, the reciprocal of each
// voxel's distance to the goal point (capped at the configured gain cap), and
// emits one result word per trajectory on the word flagged last, or at once for
// a word with has_info clear (zero gain, info_present clear). Observed voxels,
// and voxels beyond the kept-count limit, are dropped in the cycle they arrive.
// A kept voxel holds the input from the edge that takes its word to the first
// edge that can take the next, through the accept cycle, the three bit-serial
// squarers that run side by side, a state that sums the squares and loads the
// root unit, the one-bit-per-cycle square root and the registering of its
// result, then the bit-serial divider (with the distance-times-cap product
// formed beside it) and a state in which the sum takes the voxel's gain.
// The input takes a new word only when no voxel is in flight. A result
// waits in the output register while the next words are taken; a second
// result stalls the input until the first is taken.
// Configuration is written through csr_we/csr_index/csr_wdata; the user writes
// it only while the block is idle, which the block itself does not enforce.
module goal_inverse_distance_gain (
   input  logic                                  clock,
   input  logic                                  reset,
   // voxel words
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [gidg_pkg::COORD_W-1:0]   req_voxel_x,
   input  logic signed [gidg_pkg::COORD_W-1:0]   req_voxel_y,
   input  logic signed [gidg_pkg::COORD_W-1:0]   req_voxel_z,
   input  logic                                  req_observed,
   input  logic                                  req_has_info,
   input  logic                                  req_last,
   // trajectory results
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [gidg_pkg::GAIN_W-1:0]           rsp_total_gain,
   output logic [gidg_pkg::COUNT_W-1:0]          rsp_kept_count,
   output logic                                  rsp_info_present,
   output logic                                  rsp_saturated,
   // configuration
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [gidg_pkg::CAP_W-1:0]            csr_wdata
);
   import gidg_pkg::*;

   // configuration registers
   logic signed [COORD_W-1:0] goal_x_ff, goal_y_ff, goal_z_ff;
   logic [CAP_W-1:0]          gain_limit_ff;

   // control and trajectory state
   state_type             state_ff, state_in;
   logic [GAIN_W-1:0]     gain_sum_ff, gain_sum_in;
   logic [COUNT_W-1:0]    voxel_count_ff, voxel_count_in;
   logic                  sum_overflowed_ff, sum_overflowed_in;
   logic                  last_ff, last_in;
   logic                  emit_info_ff, emit_info_in;
   logic [STEP_CNT_W-1:0] sq_cnt_ff, sq_cnt_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [GAIN_W-1:0]     rsp_gain_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  rsp_info_ff, rsp_sat_ff;
   logic                  rsp_load;

   // squarer lanes, one per axis
   logic [SQ_W-1:0]       sq_mult_ff [3];
   logic [MAG_W-1:0]      sq_bits_ff [3];
   logic [SQ_W-1:0]       sq_acc_ff  [3];
   logic                  sq_load, sq_step;

   logic signed [COORD_W-1:0] vox  [3];
   logic signed [COORD_W-1:0] goal [3];
   logic signed [COORD_W:0]   diff [3];
   logic [MAG_W-1:0]          mag  [3];

   logic                  accept, keep;
   logic [SUM_W-1:0]      sq_sum;
   logic [RAD_W-1:0]      radicand;
   logic                  root_start, root_done;
   logic [ROOT_W-1:0]     root;
   logic                  recip_start, recip_done;
   logic [ADD_W-1:0]      recip_gain;
   logic [GAIN_W:0]       sum_ext;

   // ---------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         goal_z_ff     <= '0;
         gain_limit_ff <= GAIN_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GOAL_X:     goal_x_ff     <= csr_wdata;
            CSR_GOAL_Y:     goal_y_ff     <= csr_wdata;
            CSR_GOAL_Z:     goal_z_ff     <= csr_wdata;
            CSR_GAIN_LIMIT: gain_limit_ff <= csr_wdata;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Axis magnitudes |voxel - goal|, taken as the word is accepted
   // ---------------------------------------------------------------------
   always_comb begin
      vox[0]  = req_voxel_x;
      vox[1]  = req_voxel_y;
      vox[2]  = req_voxel_z;
      goal[0] = goal_x_ff;
      goal[1] = goal_y_ff;
      goal[2] = goal_z_ff;
      for (int i = 0; i < 3; i++) begin
         diff[i] = (COORD_W + 1)'(vox[i]) - (COORD_W + 1)'(goal[i]);
         mag[i]  = diff[i][COORD_W] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
      end
   end

   // ---------------------------------------------------------------------
   // Bit-serial squarers: add the shifted magnitude for each set bit
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (sq_load) begin
            sq_mult_ff[i] <= SQ_W'(mag[i]);
            sq_bits_ff[i] <= mag[i];
            sq_acc_ff[i]  <= '0;
         end else if (sq_step) begin
            sq_mult_ff[i] <= sq_mult_ff[i] << 1;
            sq_bits_ff[i] <= sq_bits_ff[i] >> 1;
            if (sq_bits_ff[i][0]) begin
               sq_acc_ff[i] <= sq_acc_ff[i] + sq_mult_ff[i];
            end
         end
      end
   end

   assign sq_sum   = SUM_W'(sq_acc_ff[0]) + SUM_W'(sq_acc_ff[1]) + SUM_W'(sq_acc_ff[2]);
   assign radicand = {sq_sum, RAD_SHIFT'(0)};

   gidg_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   gidg_recip u_recip (
      .clock      (clock),
      .reset      (reset),
      .start      (recip_start),
      .distance   (root),
      .gain_limit (gain_limit_ff),
      .done       (recip_done),
      .gain       (recip_gain)
   );

   // saturating accumulate
   assign sum_ext = {1'b0, gain_sum_ff} + (GAIN_W + 1)'(recip_gain);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   assign accept = req_valid && req_ready;
   assign keep   = !req_observed && (voxel_count_ff < COUNT_CAP);

   always_comb begin
      state_in          = state_ff;
      gain_sum_in       = gain_sum_ff;
      voxel_count_in    = voxel_count_ff;
      sum_overflowed_in = sum_overflowed_ff;
      last_in           = last_ff;
      emit_info_in      = emit_info_ff;
      sq_cnt_in         = sq_cnt_ff;
      req_ready         = 1'b0;
      sq_load           = 1'b0;
      sq_step           = 1'b0;
      root_start        = 1'b0;
      recip_start       = 1'b0;
      rsp_load          = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               last_in = req_last;
               if (!req_has_info) begin
                  // missing info: drop the partial sum, report zero
                  gain_sum_in       = '0;
                  voxel_count_in    = '0;
                  sum_overflowed_in = 1'b0;
                  emit_info_in      = 1'b0;
                  state_in          = ST_EMIT;
               end else if (keep) begin
                  sq_load   = 1'b1;
                  sq_cnt_in = '0;
                  state_in  = ST_SQUARE;
               end else if (req_last) begin
                  emit_info_in = 1'b1;
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_SQUARE: begin
            sq_step   = 1'b1;
            sq_cnt_in = sq_cnt_ff + 1'b1;
            if (sq_cnt_ff == STEP_CNT_W'(SQ_STEPS - 1)) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               recip_start = 1'b1;
               state_in    = ST_RECIP;
            end
         end
         ST_RECIP: begin
            if (recip_done) begin
               if (sum_ext[GAIN_W]) begin
                  gain_sum_in       = GAIN_MAX;
                  sum_overflowed_in = 1'b1;
               end else begin
                  gain_sum_in = sum_ext[GAIN_W-1:0];
               end
               voxel_count_in = voxel_count_ff + 1'b1;
               if (last_ff) begin
                  emit_info_in = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            // hold until the output register is free, then clear the sums
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load          = 1'b1;
               rsp_valid_in      = 1'b1;
               gain_sum_in       = '0;
               voxel_count_in    = '0;
               sum_overflowed_in = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         gain_sum_ff       <= '0;
         voxel_count_ff    <= '0;
         sum_overflowed_ff <= 1'b0;
         last_ff           <= 1'b0;
         emit_info_ff      <= 1'b0;
         sq_cnt_ff         <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         gain_sum_ff       <= gain_sum_in;
         voxel_count_ff    <= voxel_count_in;
         sum_overflowed_ff <= sum_overflowed_in;
         last_ff           <= last_in;
         emit_info_ff      <= emit_info_in;
         sq_cnt_ff         <= sq_cnt_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_gain_ff  <= gain_sum_ff;
         rsp_count_ff <= voxel_count_ff;
         rsp_info_ff  <= emit_info_ff;
         rsp_sat_ff   <= sum_overflowed_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_gain   = rsp_gain_ff;
   assign rsp_kept_count   = rsp_count_ff;
   assign rsp_info_present = rsp_info_ff;
   assign rsp_saturated    = rsp_sat_ff;

`ifndef SYNTHESIS
   a_root_done_in_root: assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == ST_ROOT)
      else $error("root unit finished outside the root phase");

   a_recip_done_in_recip: assert property (@(posedge clock) disable iff (reset)
      recip_done |-> state_ff == ST_RECIP)
      else $error("divider finished outside the divide phase");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      voxel_count_ff <= COUNT_CAP)
      else $error("kept count passed its limit");

   a_saturated_at_max: assert property (@(posedge clock) disable iff (reset)
      sum_overflowed_ff |-> gain_sum_ff == GAIN_MAX)
      else $error("saturation flag set while the sum is below its maximum");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result word raised outside the emit state");
`endif

endmodule

@@ tb/sv/gidg_result_checker.sv @@
// Result checker for goal_inverse_distance_gain: tracks the register port,
// predicts one result per finished trajectory and compares it with rsp words.
// Depends on gidg_pkg for widths, register indexes and the kept-count cap.
`timescale 1ns / 1ps

module gidg_result_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [gidg_pkg::COORD_W-1:0]  req_voxel_x,
   input  logic signed [gidg_pkg::COORD_W-1:0]  req_voxel_y,
   input  logic signed [gidg_pkg::COORD_W-1:0]  req_voxel_z,
   input  logic                                 req_observed,
   input  logic                                 req_has_info,
   input  logic                                 req_last,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [gidg_pkg::GAIN_W-1:0]          rsp_total_gain,
   input  logic [gidg_pkg::COUNT_W-1:0]         rsp_kept_count,
   input  logic                                 rsp_info_present,
   input  logic                                 rsp_saturated,
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [gidg_pkg::CAP_W-1:0]           csr_wdata,
   output int unsigned                          mismatch_count,
   output int unsigned                          awaiting,
   output int unsigned                          results_seen
);
   import gidg_pkg::*;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain;
      logic [COUNT_W-1:0] kept;
      logic               info;
      logic               sat;
   } traj_result_type;

   traj_result_type pending_results[$];

   logic signed [COORD_W-1:0] goal_x, goal_y, goal_z;
   logic [CAP_W-1:0]          gain_cap;
   logic [GAIN_W-1:0]         gain_acc;
   logic [COUNT_W-1:0]        kept_acc;
   logic                      acc_sat;
   int unsigned               fails;
   int unsigned               seen;

   function automatic logic [47:0] axis_square(input logic signed [COORD_W-1:0] a,
                                               input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] diff;
      logic [COORD_W-1:0]      mag;
      diff = a - b;
      mag  = COORD_W'(diff[COORD_W] ? -diff : diff);
      return 48'(mag) * 48'(mag);
   endfunction

   // Per-voxel gain in Q.16: reciprocal distance, or the cap when too close.
   function automatic logic [31:0] voxel_gain(input logic signed [COORD_W-1:0] vx,
                                              input logic signed [COORD_W-1:0] vy,
                                              input logic signed [COORD_W-1:0] vz);
      logic [49:0] sq_sum;
      logic [63:0] radicand;
      logic [31:0] span;
      logic [31:0] trial;
      logic [55:0] reach;
      sq_sum   = 50'(axis_square(vx, goal_x)) + 50'(axis_square(vy, goal_y))
               + 50'(axis_square(vz, goal_z));
      radicand = {sq_sum, 14'b0};
      span     = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = span | (32'd1 << i);
         if (64'(trial) * 64'(trial) <= radicand)
            span = trial;
      end
      reach = 56'(span) * 56'(gain_cap);
      if (reach > (56'd1 << 23))
         return 32'((64'd1 << 31) / 64'(span));
      return {gain_cap, 8'b0};
   endfunction

   always @(posedge clock) begin : track
      traj_result_type got;
      traj_result_type want;
      logic [31:0]     add;
      logic [48:0]     total;
      if (reset) begin
         goal_x   = '0;
         goal_y   = '0;
         goal_z   = '0;
         gain_cap = GAIN_LIMIT_RESET;
         gain_acc = '0;
         kept_acc = '0;
         acc_sat  = 1'b0;
         pending_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GOAL_X:     goal_x   = csr_wdata;
               CSR_GOAL_Y:     goal_y   = csr_wdata;
               CSR_GOAL_Z:     goal_z   = csr_wdata;
               CSR_GAIN_LIMIT: gain_cap = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            got = '{gain: rsp_total_gain, kept: rsp_kept_count,
                    info: rsp_info_present, sat: rsp_saturated};
            seen++;
            if (pending_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected result gain %h kept %0d info %b sat %b",
                           $time, got.gain, got.kept, got.info, got.sat);
            end else begin
               want = pending_results.pop_front();
               if (got.gain !== want.gain || got.kept !== want.kept ||
                   got.info !== want.info || got.sat !== want.sat) begin
                  fails++;
                  if (fails <= 10)
                     $display({"%0t: result %0d mismatch: expected gain %h kept %0d ",
                               "info %b sat %b, got gain %h kept %0d info %b sat %b"},
                              $time, seen, want.gain, want.kept, want.info, want.sat,
                              got.gain, got.kept, got.info, got.sat);
               end
            end
         end

         if (req_valid && req_ready) begin
            if (!req_has_info) begin
               // missing info: drop the partial sum and report an empty trajectory
               gain_acc = '0;
               kept_acc = '0;
               acc_sat  = 1'b0;
               pending_results.push_back('{gain: '0, kept: '0, info: 1'b0, sat: 1'b0});
            end else begin
               if (!req_observed && kept_acc < COUNT_CAP) begin
                  add   = voxel_gain(req_voxel_x, req_voxel_y, req_voxel_z);
                  total = {1'b0, gain_acc} + 49'(add);
                  if (total > {1'b0, GAIN_MAX}) begin
                     gain_acc = GAIN_MAX;
                     acc_sat  = 1'b1;
                  end else begin
                     gain_acc = total[GAIN_W-1:0];
                  end
                  kept_acc++;
               end
               if (req_last) begin
                  pending_results.push_back('{gain: gain_acc, kept: kept_acc,
                                              info: 1'b1, sat: acc_sat});
                  gain_acc = '0;
                  kept_acc = '0;
                  acc_sat  = 1'b0;
               end
            end
         end
      end
      mismatch_count <= fails;
      awaiting       <= pending_results.size();
      results_seen   <= seen;
   end

endmodule

@@ tb/sv/goal_inverse_distance_gain_tb.sv @@
// Testbench top for goal_inverse_distance_gain: drives voxel words and
// register writes, stalls the result side, and reports the verdict.
// Depends on gidg_pkg, the block itself and gidg_result_checker.
`timescale 1ns / 1ps

module goal_inverse_distance_gain_tb;
   import gidg_pkg::*;

   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 110;   // random words per register setting
   localparam int SETTLE       = 120;   // idle time after the last result is back
   localparam int CYCLE_LIMIT  = 2000000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_voxel_x = '0;
   logic signed [COORD_W-1:0] req_voxel_y = '0;
   logic signed [COORD_W-1:0] req_voxel_z = '0;
   logic                      req_observed = 1'b0;
   logic                      req_has_info = 1'b0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [GAIN_W-1:0]         rsp_total_gain;
   logic [COUNT_W-1:0]        rsp_kept_count;
   logic                      rsp_info_present;
   logic                      rsp_saturated;
   logic                      csr_we = 1'b0;
   logic [1:0]                csr_index = '0;
   logic [CAP_W-1:0]          csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned awaiting;
   int unsigned results_seen;

   // stimulus bookkeeping
   logic        calm = 1'b0;        // high: no gaps and no stalls
   int unsigned cycles = 0;
   int unsigned words_sent = 0;
   int unsigned settings_used = 0;
   int          stall_left = 0;
   logic [COORD_W-1:0] goal_x_set = '0;
   logic [COORD_W-1:0] goal_y_set = '0;
   logic [COORD_W-1:0] goal_z_set = '0;

   goal_inverse_distance_gain u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_voxel_x      (req_voxel_x),
      .req_voxel_y      (req_voxel_y),
      .req_voxel_z      (req_voxel_z),
      .req_observed     (req_observed),
      .req_has_info     (req_has_info),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_total_gain   (rsp_total_gain),
      .rsp_kept_count   (rsp_kept_count),
      .rsp_info_present (rsp_info_present),
      .rsp_saturated    (rsp_saturated),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   gidg_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_voxel_x      (req_voxel_x),
      .req_voxel_y      (req_voxel_y),
      .req_voxel_z      (req_voxel_z),
      .req_observed     (req_observed),
      .req_has_info     (req_has_info),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_total_gain   (rsp_total_gain),
      .rsp_kept_count   (rsp_kept_count),
      .rsp_info_present (rsp_info_present),
      .rsp_saturated    (rsp_saturated),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .awaiting         (awaiting),
      .results_seen     (results_seen)
   );

   always #5 clock = ~clock;

   // Give up on a hung block well past the slowest legal run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still awaited", cycles, awaiting);
         $display("Some tests failed");
         $finish;
      end
   end

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int next_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm)
         return 0;
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // Result side: hold ready low for a random stall, then raise it again.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= next_gap();
      end
   end

   // Present one word and hold it until the block takes it. Valid stays high
   // into the next word unless a gap follows.
   task automatic send_word(input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy,
                            input logic [COORD_W-1:0] vz, input logic obs,
                            input logic info, input logic fin);
      int gap;
      req_valid    <= 1'b1;
      req_voxel_x  <= vx;
      req_voxel_y  <= vy;
      req_voxel_z  <= vz;
      req_observed <= obs;
      req_has_info <= info;
      req_last     <= fin;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      gap = next_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected result has come back, then
   // let the block settle for the given number of cycles.
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write all four registers back to back; only called while the block is idle.
   task automatic write_config(input logic [COORD_W-1:0] gx, input logic [COORD_W-1:0] gy,
                               input logic [COORD_W-1:0] gz, input logic [CAP_W-1:0] cap);
      goal_x_set = gx;
      goal_y_set = gy;
      goal_z_set = gz;
      settings_used++;
      csr_we    <= 1'b1;
      csr_index <= CSR_GOAL_X;
      csr_wdata <= gx;
      @(posedge clock);
      csr_index <= CSR_GOAL_Y;
      csr_wdata <= gy;
      @(posedge clock);
      csr_index <= CSR_GOAL_Z;
      csr_wdata <= gz;
      @(posedge clock);
      csr_index <= CSR_GAIN_LIMIT;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Coordinate around a goal axis: mostly close, sometimes far or at the rails.
   function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] centre);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return centre + COORD_W'($urandom_range(0, 2048)) - COORD_W'(1024);
      if (r < 75)
         return centre + COORD_W'($urandom_range(0, 131072)) - COORD_W'(65536);
      if (r < 90)
         return COORD_W'($urandom);
      if (r < 94)
         return 24'h800000;
      if (r < 98)
         return 24'h7FFFFF;
      return centre;
   endfunction

   function automatic logic [COORD_W-1:0] pick_goal();
      if ($urandom_range(0, 1) == 0)
         return COORD_W'($urandom);
      return COORD_W'($urandom_range(0, 8192)) - COORD_W'(4096);
   endfunction

   function automatic logic [CAP_W-1:0] pick_cap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30)
         return GAIN_LIMIT_RESET;
      if (r < 60)
         return CAP_W'($urandom_range(1, 255));
      return CAP_W'($urandom_range(1, 24'hFFFFFF));
   endfunction

   // One trajectory: well-formed voxels with random content, now and then a
   // missing-info word on its own or breaking into the middle of one.
   task automatic send_trajectory();
      int len;
      if ($urandom_range(0, 99) < 6) begin
         send_word(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                   1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
      end else begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 49) == 0)
               send_word(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                         1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
            send_word(pick_coord(goal_x_set), pick_coord(goal_y_set), pick_coord(goal_z_set),
                      $urandom_range(0, 3) == 0, 1'b1, i == len - 1);
            // occasionally hold off the sender until everything is back
            if ($urandom_range(0, 199) == 0)
               drain(0);
         end
      end
   endtask

   initial begin
      int unsigned phase_start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset setting: goal at the origin, cap 100.0.
      send_word(24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b1, 1'b0);  // at the goal
      send_word(24'h000100, 24'h000000, 24'h000000, 1'b0, 1'b1, 1'b0);  // one metre
      send_word(24'h000001, 24'h000001, 24'h000001, 1'b1, 1'b1, 1'b0);  // observed
      send_word(24'h000000, 24'h000000, 24'h000001, 1'b0, 1'b1, 1'b1);  // inside cap
      send_word(24'h000005, 24'h000006, 24'h000007, 1'b1, 1'b1, 1'b1);  // all observed
      send_word(24'h000064, 24'h0000C8, 24'h00012C, 1'b0, 1'b1, 1'b0);
      send_word(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0, 1'b0);  // missing info
      send_word(24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0, 1'b1);  // missing info
      send_word(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0, 1'b1, 1'b1);
      send_word(24'h800000, 24'h7FFFFF, 24'h800000, 1'b0, 1'b1, 1'b1);
      drain(SETTLE);

      // Goal at the far corner with the largest cap: longest distances.
      write_config(24'h800000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF);
      send_word(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0, 1'b1, 1'b0);
      send_word(24'h800000, 24'h7FFFFF, 24'h800000, 1'b0, 1'b1, 1'b0);
      send_word(24'h800001, 24'h7FFFFF, 24'h800000, 1'b0, 1'b1, 1'b1);
      drain(SETTLE);

      // Zero cap: every kept voxel adds nothing.
      write_config(24'h000000, 24'h000000, 24'h000000, 24'h000000);
      send_word(24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b1, 1'b0);
      send_word(24'h000100, 24'h000100, 24'h000100, 1'b0, 1'b1, 1'b1);
      drain(SETTLE);

      // Smallest nonzero cap.
      write_config(24'h000000, 24'h000000, 24'h000000, 24'h000001);
      send_word(24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b1, 1'b0);
      send_word(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b1, 1'b1);
      drain(SETTLE);

      // Random trajectories, one register setting per phase.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: write_config(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
            1: write_config(pick_goal(), pick_goal(), pick_goal(), 24'h000000);
            2: write_config(pick_goal(), pick_goal(), pick_goal(), 24'h000001);
            default: write_config(pick_goal(), pick_goal(), pick_goal(), pick_cap());
         endcase
         calm <= (p % 4 == 3);
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS)
            send_trajectory();
         drain(SETTLE);
      end

      $display("Covered %0d voxel words under %0d register settings (reset one included),",
               words_sent, settings_used + 1);
      $display("with %0d trajectory results compared against the predicted gain.",
               results_seen);
      if (mismatch_count == 0 && awaiting == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
